// ===== rtl/nsbfa_pkg.sv =====
package nsbfa_pkg;

    localparam int ADDR_W      = 64;
    localparam int WORD_W      = 32;
    localparam int BYTES_W     = 32;
    localparam int NOP_COUNT_W = 16;
    localparam int WANT_W      = NOP_COUNT_W + 2;

    localparam int MAX_REGIONS_DEF   = 64;
    localparam int MIN_RUN_WORDS_DEF = 11;

    localparam logic [WORD_W-1:0] NOP_OPCODE_RESET = 32'hD503_201F;

    localparam logic OP_SCAN  = 1'b0;
    localparam logic OP_ALLOC = 1'b1;

    localparam logic STATUS_FOUND = 1'b0;
    localparam logic STATUS_NONE  = 1'b1;

    // One entry of the free-region table.
    typedef struct packed {
        logic [ADDR_W-1:0]  start;
        logic [BYTES_W-1:0] bytes;
    } region_t;

endpackage

// ===== rtl/nsbfa_cell.sv =====
module nsbfa_cell
    import nsbfa_pkg::*;
#(
    parameter int MAX_REGIONS = MAX_REGIONS_DEF,
    parameter int INDEX       = 0
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic [$clog2(MAX_REGIONS+1)-1:0]       count,
    input  logic [WANT_W-1:0]                      want,
    input  logic [BYTES_W+ADDR_W+2*$clog2(MAX_REGIONS)+2-1:0] cmd,
    input  logic                                   tok_in_valid,
    input  logic [1+BYTES_W+ADDR_W+$clog2(MAX_REGIONS)-1:0] tok_in,
    output logic                                   tok_out_valid,
    output logic [1+BYTES_W+ADDR_W+$clog2(MAX_REGIONS)-1:0] tok_out,
    input  region_t                                ent_right,
    output region_t                                ent_out
);

    localparam int IDX_W = $clog2(MAX_REGIONS);
    localparam int CNT_W = $clog2(MAX_REGIONS + 1);
    localparam logic [CNT_W-1:0] INDEX_C = CNT_W'(INDEX);
    localparam logic [IDX_W-1:0] INDEX_I = IDX_W'(INDEX);

    typedef struct packed {
        logic               found;
        logic [BYTES_W-1:0] bytes;
        logic [ADDR_W-1:0]  start;
        logic [IDX_W-1:0]   idx;
    } token_t;

    typedef struct packed {
        logic             wr;
        logic [IDX_W-1:0] wr_idx;
        region_t          wr_ent;
        logic             shift;
        logic [IDX_W-1:0] shift_idx;
    } cmd_t;

    cmd_t    cmd_s;
    token_t  tin;
    token_t  tok_next;
    token_t  tok_reg;
    logic    tok_valid_reg;
    region_t ent_reg;
    logic    fit;

    assign cmd_s = cmd_t'(cmd);
    assign tin   = token_t'(tok_in);

    // Take over the token when this entry fits and is strictly smaller.
    always_comb begin
        fit = tok_in_valid && (INDEX_C < count) && (BYTES_W'(want) <= ent_reg.bytes)
              && (!tin.found || (ent_reg.bytes < tin.bytes));
        tok_next = tin;
        if (fit) begin
            tok_next.found = 1'b1;
            tok_next.bytes = ent_reg.bytes;
            tok_next.start = ent_reg.start;
            tok_next.idx   = INDEX_I;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_valid_reg <= 1'b0;
        end else begin
            tok_valid_reg <= tok_in_valid;
        end
        tok_reg <= tok_next;
    end

    // Write has priority over the compaction shift.
    always_ff @(posedge aclk) begin
        if (cmd_s.wr && (cmd_s.wr_idx == INDEX_I)) begin
            ent_reg <= cmd_s.wr_ent;
        end else if (cmd_s.shift && (INDEX_I >= cmd_s.shift_idx)) begin
            ent_reg <= ent_right;
        end
    end

    assign tok_out_valid = tok_valid_reg;
    assign tok_out       = tok_reg;
    assign ent_out       = ent_reg;

endmodule

// ===== rtl/nsbfa_chain.sv =====
module nsbfa_chain
    import nsbfa_pkg::*;
#(
    parameter int MAX_REGIONS = MAX_REGIONS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic [$clog2(MAX_REGIONS+1)-1:0]       count,
    input  logic [WANT_W-1:0]                      want,
    input  logic [BYTES_W+ADDR_W+2*$clog2(MAX_REGIONS)+2-1:0] cmd,
    input  logic                                   launch,
    output logic                                   done,
    output logic [1+BYTES_W+ADDR_W+$clog2(MAX_REGIONS)-1:0] result
);

    localparam int TOK_W = 1 + BYTES_W + ADDR_W + $clog2(MAX_REGIONS);

    logic [TOK_W-1:0] tok   [MAX_REGIONS+1];
    logic             tok_v [MAX_REGIONS+1];
    region_t          ent   [MAX_REGIONS];

    // Fresh token: nothing found yet.
    assign tok[0]   = '0;
    assign tok_v[0] = launch;

    for (genvar i = 0; i < MAX_REGIONS; i++) begin : g_cell
        region_t right;
        if (i == MAX_REGIONS - 1) begin : g_last
            assign right = ent[i];
        end else begin : g_mid
            assign right = ent[i+1];
        end

        nsbfa_cell #(
            .MAX_REGIONS (MAX_REGIONS),
            .INDEX       (i)
        ) u_cell (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .count         (count),
            .want          (want),
            .cmd           (cmd),
            .tok_in_valid  (tok_v[i]),
            .tok_in        (tok[i]),
            .tok_out_valid (tok_v[i+1]),
            .tok_out       (tok[i+1]),
            .ent_right     (right),
            .ent_out       (ent[i])
        );
    end

    assign done   = tok_v[MAX_REGIONS];
    assign result = tok[MAX_REGIONS];

endmodule

// ===== rtl/nop_space_best_fit_allocator_unit.sv =====
// Channel   | Handshake        | Payload
// ----------+------------------+---------------------------------------------------
// s_ (in)   | s_valid/s_ready  | s_op, s_code_word, s_word_address, s_nop_count,
//           |                  | s_consume
// m_ (out)  | m_valid/m_ready  | m_status, m_region_address
// cfg       | cfg_wr_en        | cfg_wr_data (nop opcode)
//
// Scanned code words stream at one per cycle while s_ready is high.
// An allocation request passes launch_reg, then the row of region cells (the search
// token walks them one cell per cycle), then best_reg, which latches the winner, and
// last the step that updates the table and loads the output register once it is free.
// Reset (aresetn low, synchronous) empties the table, closes no scan and loads the
// default nop opcode; table entries themselves are not cleared.
// s_ready is low from a request transfer until its result sits in the output
// register; a stalled m_ready holds the block in the result state.
module nop_space_best_fit_allocator_unit
    import nsbfa_pkg::*;
#(
    parameter int MAX_REGIONS   = MAX_REGIONS_DEF,
    parameter int MIN_RUN_WORDS = MIN_RUN_WORDS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [WORD_W-1:0]      cfg_wr_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_op,
    input  logic [WORD_W-1:0]      s_code_word,
    input  logic [ADDR_W-1:0]      s_word_address,
    input  logic [NOP_COUNT_W-1:0] s_nop_count,
    input  logic                   s_consume,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_status,
    output logic [ADDR_W-1:0]      m_region_address
);

    localparam int IDX_W = $clog2(MAX_REGIONS);
    localparam int CNT_W = $clog2(MAX_REGIONS + 1);
    localparam logic [CNT_W-1:0]  MAX_C         = CNT_W'(MAX_REGIONS);
    localparam logic [ADDR_W-1:0] MIN_RUN_BYTES = ADDR_W'(4 * MIN_RUN_WORDS);

    typedef struct packed {
        logic               found;
        logic [BYTES_W-1:0] bytes;
        logic [ADDR_W-1:0]  start;
        logic [IDX_W-1:0]   idx;
    } token_t;

    typedef struct packed {
        logic             wr;
        logic [IDX_W-1:0] wr_idx;
        region_t          wr_ent;
        logic             shift;
        logic [IDX_W-1:0] shift_idx;
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DONE
    } state_t;

    state_t             state_reg,   state_next;
    logic [CNT_W-1:0]   count_reg,   count_next;
    logic               in_run_reg,  in_run_next;
    logic [ADDR_W-1:0]  run_start_reg, run_start_next;
    logic               closed_reg,  closed_next;
    logic [WORD_W-1:0]  nop_opcode_reg;
    logic [WANT_W-1:0]  want_reg,    want_next;
    logic               consume_reg, consume_next;
    logic               launch_reg,  launch_next;
    token_t             best_reg,    best_next;
    logic               m_valid_reg, m_valid_next;
    logic               m_status_reg, m_status_next;
    logic [ADDR_W-1:0]  m_addr_reg,  m_addr_next;

    cmd_t               cmd;
    logic               chain_done;
    logic [$bits(token_t)-1:0] chain_result;

    logic               s_xfer;
    logic               is_free;
    logic [ADDR_W-1:0]  run_len;
    logic               out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_xfer   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign is_free  = (s_code_word == nop_opcode_reg) || (s_code_word == '0);
    assign run_len  = s_word_address - run_start_reg;

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        in_run_next    = in_run_reg;
        run_start_next = run_start_reg;
        closed_next    = closed_reg;
        want_next      = want_reg;
        consume_next   = consume_reg;
        launch_next    = 1'b0;
        best_next      = best_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_status_next  = m_status_reg;
        m_addr_next    = m_addr_reg;
        cmd            = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_xfer && (s_op == OP_SCAN)) begin
                    // Words after the first request are dropped.
                    if (!closed_reg) begin
                        if (is_free) begin
                            if (!in_run_reg) begin
                                in_run_next    = 1'b1;
                                run_start_next = s_word_address;
                            end
                        end else if (in_run_reg) begin
                            in_run_next = 1'b0;
                            if ((run_len >= MIN_RUN_BYTES) && (count_reg < MAX_C)) begin
                                cmd.wr           = 1'b1;
                                cmd.wr_idx       = count_reg[IDX_W-1:0];
                                cmd.wr_ent.start = run_start_reg;
                                // Saturate sizes beyond 32 bits.
                                cmd.wr_ent.bytes = (run_len[ADDR_W-1:BYTES_W] != '0)
                                                   ? '1 : run_len[BYTES_W-1:0];
                                count_next       = count_reg + 1'b1;
                            end
                        end
                    end
                end else if (s_xfer) begin
                    // First request closes the scan and appends the empty marker;
                    // any open run is dropped.
                    if (!closed_reg) begin
                        closed_next = 1'b1;
                        in_run_next = 1'b0;
                        if (count_reg < MAX_C) begin
                            cmd.wr     = 1'b1;
                            cmd.wr_idx = count_reg[IDX_W-1:0];
                            count_next = count_reg + 1'b1;
                        end
                    end
                    want_next    = {s_nop_count, 2'b00};
                    consume_next = s_consume;
                    launch_next  = 1'b1;
                    state_next   = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (chain_done) begin
                    best_next  = token_t'(chain_result);
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = best_reg.found ? STATUS_FOUND : STATUS_NONE;
                    m_addr_next   = best_reg.found ? best_reg.start : '0;
                    if (best_reg.found && consume_reg) begin
                        // Close the gap, then put any remainder in the freed last slot.
                        cmd.shift     = 1'b1;
                        cmd.shift_idx = best_reg.idx;
                        if (BYTES_W'(want_reg) < best_reg.bytes) begin
                            cmd.wr           = 1'b1;
                            cmd.wr_idx       = IDX_W'(count_reg - 1'b1);
                            cmd.wr_ent.start = best_reg.start + ADDR_W'(want_reg);
                            cmd.wr_ent.bytes = best_reg.bytes - BYTES_W'(want_reg);
                        end else begin
                            count_next = count_reg - 1'b1;
                        end
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            in_run_reg     <= 1'b0;
            run_start_reg  <= '0;
            closed_reg     <= 1'b0;
            launch_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
            nop_opcode_reg <= NOP_OPCODE_RESET;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            in_run_reg    <= in_run_next;
            run_start_reg <= run_start_next;
            closed_reg    <= closed_next;
            launch_reg    <= launch_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_wr_en) begin
                nop_opcode_reg <= cfg_wr_data;
            end
        end
        want_reg     <= want_next;
        consume_reg  <= consume_next;
        best_reg     <= best_next;
        m_status_reg <= m_status_next;
        m_addr_reg   <= m_addr_next;
    end

    nsbfa_chain #(
        .MAX_REGIONS (MAX_REGIONS)
    ) u_chain (
        .aclk    (aclk),
        .aresetn (aresetn),
        .count   (count_reg),
        .want    (want_reg),
        .cmd     (cmd),
        .launch  (launch_reg),
        .done    (chain_done),
        .result  (chain_result)
    );

    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_region_address = m_addr_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= MAX_C)
        else $error("region count beyond table size");

    a_launch_state: assert property (@(posedge aclk) disable iff (!aresetn)
        launch_reg |-> (state_reg == ST_SEARCH))
        else $error("search token launched outside search");

    a_token_state: assert property (@(posedge aclk) disable iff (!aresetn)
        chain_done |-> (state_reg == ST_SEARCH))
        else $error("search token arrived outside search");

    a_done_output: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_DONE) && out_free) |=> (m_valid_reg && (state_reg == ST_IDLE)))
        else $error("finished request did not load the output register");

endmodule
